// ===== hdl/sha1_message_digest_core_assert.svh =====
// Assertion macros shared by the SHA-1 digest core RTL
`ifndef SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SHA1MD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SHA1MD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sha1md_pkg.sv =====
// Types, constants and round functions of the SHA-1 digest core
`timescale 1ns / 1ps
package sha1md_pkg;

	localparam int NUM_WORDS = 5;
	localparam int NUM_ROUNDS = 80;
	localparam logic [2:0] LAST_IDX = 3'd4;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] FILL_TOP = 6'd63;
	localparam logic [6:0] ROUND_TOP = 7'd79;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [NUM_WORDS-1:0][31:0] IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_COMP  = 5'b00010,
		ST_FINAL = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic shift;
	} sched_ctrl_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic [6:0] rnd;
	} round_ctrl_t;

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) k = K0;
		else if (rnd < 7'd40) k = K1;
		else if (rnd < 7'd60) k = K2;
		else k = K3;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) f = (b & c) | (~b & d);
		else if (rnd >= 7'd40 && rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction

endpackage

// ===== hdl/sha1md_sched.sv =====
// Block buffer and message schedule window of the SHA-1 digest core
`timescale 1ns / 1ps
module sha1md_sched (
	input  logic                      clk,
	input  sha1md_pkg::sched_ctrl_t   ctrl,
	input  logic [5:0]                wr_addr,
	input  logic [7:0]                wr_data,
	output logic [31:0]               wt
);

	logic [15:0][31:0] words_q;
	logic [31:0]       mix;
	logic [31:0]       next_word;

	assign wt = words_q[0];
	assign mix = words_q[13] ^ words_q[8] ^ words_q[2] ^ words_q[0];
	assign next_word = {mix[30:0], mix[31]};

	// Bytes land big-endian; during rounds the window slides one word a cycle
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int i = 0; i < 15; i++) begin
				words_q[i] <= words_q[i+1];
			end
			words_q[15] <= next_word;
		end else if (ctrl.wr_en) begin
			words_q[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
		end
	end

endmodule

// ===== hdl/sha1md_round.sv =====
// Shared SHA-1 round unit with its working variables
`timescale 1ns / 1ps
module sha1md_round (
	input  logic                                        clk,
	input  sha1md_pkg::round_ctrl_t                     ctrl,
	input  logic [sha1md_pkg::NUM_WORDS-1:0][31:0]      chain,
	input  logic [31:0]                                 wt,
	output logic [sha1md_pkg::NUM_WORDS-1:0][31:0]      work
);

	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] sum;

	assign sum = {a_q[26:0], a_q[31:27]} + sha1md_pkg::round_f(ctrl.rnd, b_q, c_q, d_q)
		+ e_q + sha1md_pkg::round_k(ctrl.rnd) + wt;

	assign work = {e_q, d_q, c_q, b_q, a_q};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= chain[0];
			b_q <= chain[1];
			c_q <= chain[2];
			d_q <= chain[3];
			e_q <= chain[4];
		end else if (ctrl.step) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= sum;
		end
	end

endmodule

// ===== hdl/sha1_message_digest_core.sv =====
// SHA-1 digest core: one message byte per item, five digest words per message
// Flow: a byte that leaves the block short is only written into the block buffer; a byte that fills it
//   also starts compression (load, 80 rounds on the one shared round unit, chain update).
// Closing a message writes the padding bytes, compresses each padded block and sends out the five words.
// Throughput: 1 byte per cycle while idle; msg_stall holds input off during compression, padding and output.
// Reset: chaining words to the SHA-1 initial values, byte and fill counts to zero.
//   The block buffer is not cleared; every entry is written before it is read.
`timescale 1ns / 1ps
`include "sha1_message_digest_core_assert.svh"
module sha1_message_digest_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_stall,
	input  sha1md_pkg::msg_t      msg_item,
	output logic                  digest_valid,
	input  logic                  digest_stall,
	output sha1md_pkg::digest_t   digest_item
);

	sha1md_pkg::state_t state_q, ret_q;
	logic [6:0]  round_q;
	logic [5:0]  fill_q;
	logic [63:0] count_q;
	logic        sent80_q;
	logic        len_q;
	logic [2:0]  widx_q;
	logic [sha1md_pkg::NUM_WORDS-1:0][31:0] chain_q;
	logic [sha1md_pkg::NUM_WORDS-1:0][31:0] work;
	logic        digest_valid_q;
	sha1md_pkg::digest_t digest_q;

	sha1md_pkg::sched_ctrl_t sched_ctrl;
	sha1md_pkg::round_ctrl_t round_ctrl;
	logic [31:0] wt;

	logic        msg_acc;
	logic        push_en;
	logic [7:0]  push_data;
	logic        full;
	logic        byte_is_len;
	logic        last_len;
	logic [63:0] bit_len;
	logic [7:0]  len_byte;
	logic        out_load;

	assign msg_stall = (state_q != sha1md_pkg::ST_IDLE);
	assign msg_acc = msg_valid && !msg_stall;

	assign bit_len = {count_q[60:0], 3'b000};
	assign len_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
	assign byte_is_len = len_q || (sent80_q && fill_q == sha1md_pkg::LEN_POS);
	assign last_len = byte_is_len && fill_q == sha1md_pkg::FILL_TOP;

	always_comb begin
		push_en = 1'b0;
		push_data = msg_item.data_byte;
		if (state_q == sha1md_pkg::ST_IDLE) begin
			push_en = msg_acc && msg_item.has_byte;
		end else if (state_q == sha1md_pkg::ST_PAD) begin
			push_en = 1'b1;
			if (!sent80_q) push_data = sha1md_pkg::PAD_MARK;
			else if (byte_is_len) push_data = len_byte;
			else push_data = 8'h00;
		end
	end

	assign full = push_en && fill_q == sha1md_pkg::FILL_TOP;

	assign sched_ctrl.wr_en = push_en;
	assign sched_ctrl.shift = (state_q == sha1md_pkg::ST_COMP);
	assign round_ctrl.load = full;
	assign round_ctrl.step = (state_q == sha1md_pkg::ST_COMP);
	assign round_ctrl.rnd = round_q;

	sha1md_sched u_sched (
		.clk     (clk),
		.ctrl    (sched_ctrl),
		.wr_addr (fill_q),
		.wr_data (push_data),
		.wt      (wt)
	);

	sha1md_round u_round (
		.clk   (clk),
		.ctrl  (round_ctrl),
		.chain (chain_q),
		.wt    (wt),
		.work  (work)
	);

	assign out_load = (state_q == sha1md_pkg::ST_OUT) && (!digest_valid_q || !digest_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha1md_pkg::ST_IDLE;
			ret_q    <= sha1md_pkg::ST_IDLE;
			round_q  <= '0;
			fill_q   <= '0;
			count_q  <= '0;
			sent80_q <= 1'b0;
			len_q    <= 1'b0;
			widx_q   <= '0;
			chain_q  <= sha1md_pkg::IV;
		end else begin
			if (push_en) fill_q <= fill_q + 6'd1;
			if (msg_acc && msg_item.has_byte) count_q <= count_q + 64'd1;
			unique case (state_q)
				sha1md_pkg::ST_IDLE: begin
					if (msg_acc) begin
						if (full) begin
							state_q <= sha1md_pkg::ST_COMP;
							ret_q <= msg_item.is_last ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE;
						end else if (msg_item.is_last) begin
							state_q <= sha1md_pkg::ST_PAD;
						end
					end
				end
				sha1md_pkg::ST_PAD: begin
					sent80_q <= 1'b1;
					if (byte_is_len) len_q <= 1'b1;
					if (full) begin
						state_q <= sha1md_pkg::ST_COMP;
						ret_q <= last_len ? sha1md_pkg::ST_OUT : sha1md_pkg::ST_PAD;
					end
				end
				sha1md_pkg::ST_COMP: begin
					// advance one round a cycle; leave after the last
					if (round_q == sha1md_pkg::ROUND_TOP) begin
						round_q <= '0;
						state_q <= sha1md_pkg::ST_FINAL;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				sha1md_pkg::ST_FINAL: begin
					for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					widx_q <= '0;
					state_q <= ret_q;
				end
				sha1md_pkg::ST_OUT: begin
					if (out_load) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == sha1md_pkg::LAST_IDX) begin
							// digest gone out: start a fresh message
							state_q  <= sha1md_pkg::ST_IDLE;
							chain_q  <= sha1md_pkg::IV;
							count_q  <= '0;
							sent80_q <= 1'b0;
							len_q    <= 1'b0;
						end
					end
				end
				default: state_q <= sha1md_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_valid_q <= 1'b0;
		end else if (out_load) begin
			digest_valid_q <= 1'b1;
		end else if (!digest_stall) begin
			digest_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			digest_q.digest_word <= chain_q[widx_q];
			digest_q.word_index  <= widx_q;
			digest_q.last_word   <= (widx_q == sha1md_pkg::LAST_IDX);
		end
	end

	assign digest_valid = digest_valid_q;
	assign digest_item = digest_q;

	`SHA1MD_ASSERT_NXT(a_round_end, state_q == sha1md_pkg::ST_COMP && round_q == sha1md_pkg::ROUND_TOP, state_q == sha1md_pkg::ST_FINAL, "compression did not close after the last round")
	`SHA1MD_ASSERT_IMP(a_round_idle, state_q != sha1md_pkg::ST_COMP, round_q == 7'd0, "round counter running outside compression")
	`SHA1MD_ASSERT_IMP(a_out_fill, state_q == sha1md_pkg::ST_OUT, fill_q == 6'd0 && len_q, "digest out with a partly filled block")
	`SHA1MD_ASSERT_NXT(a_last_word, out_load, digest_item.last_word == (digest_item.word_index == sha1md_pkg::LAST_IDX), "last word flag out of step with word index")
	`SHA1MD_ASSERT_IMP(a_len_order, len_q, sent80_q, "length bytes before the padding mark")

endmodule
